[sv/assert_macros.svh]
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBFD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/sbfd_pkg.sv]
// Shared constants and the frame entry type for the SBUS frame decoder.
// Used by the parser, the frame queue, the channel unpacker and the top level.
package sbfd_pkg;

	localparam logic [7:0] START_BYTE = 8'h0F;
	localparam logic [7:0] END_BYTE = 8'h00;

	localparam int unsigned PAYLOAD_LEN = 23;
	localparam int unsigned CHAN_BYTES = 22;
	localparam int unsigned NUM_CHANNELS = 16;
	localparam int unsigned CH_BITS = 11;
	localparam int unsigned CHAN_VEC_W = CHAN_BYTES * 8;

	// One accepted frame: packed channel bits, flags nibble and frame number.
	typedef struct packed {
		logic [CHAN_VEC_W-1:0] chan_bits;
		logic [3:0]            flags;
		logic [31:0]           count;
	} frame_t;

endpackage

[sv/sbfd_front.sv]
// Byte parser: hunts for the start byte, collects the payload, checks the end byte.
// Depends on sbfd_pkg and assert_macros.svh; pushes whole frames into the frame queue.
`include "assert_macros.svh"
module sbfd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	input  logic                 q_full,
	output logic                 push,
	output sbfd_pkg::frame_t     push_frame
);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_DATA = 2'd1;
	localparam logic [1:0] PH_END  = 2'd2;

	logic [1:0]  phase_q;
	logic [4:0]  byte_cnt_q;
	logic [7:0]  store_q [sbfd_pkg::PAYLOAD_LEN];
	logic [31:0] frames_q;
	logic        take;
	logic [4:0]  cnt_next;

	// Only the end byte may need room in the queue.
	assign in_ready = (phase_q != PH_END) || !q_full;
	assign take = in_valid && in_ready;
	assign cnt_next = byte_cnt_q + 5'd1;
	assign push = take && (phase_q == PH_END) && (rx_byte == sbfd_pkg::END_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			byte_cnt_q <= '0;
			frames_q <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_DATA: begin
					byte_cnt_q <= cnt_next;
					if (cnt_next >= 5'(sbfd_pkg::PAYLOAD_LEN)) begin
						phase_q <= PH_END;
					end
				end
				PH_END: begin
					if (push) begin
						frames_q <= frames_q + 32'd1;
					end
					phase_q <= PH_HUNT;
				end
				default: begin
					if (rx_byte == sbfd_pkg::START_BYTE) begin
						byte_cnt_q <= '0;
						phase_q <= PH_DATA;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && (phase_q == PH_DATA) && (byte_cnt_q < 5'(sbfd_pkg::PAYLOAD_LEN))) begin
			store_q[byte_cnt_q] <= rx_byte;
		end
	end

	always_comb begin
		for (int j = 0; j < sbfd_pkg::CHAN_BYTES; j++) begin
			push_frame.chan_bits[8*j +: 8] = store_q[j];
		end
		push_frame.flags = store_q[sbfd_pkg::PAYLOAD_LEN-1][7:4];
		push_frame.count = frames_q + 32'd1;
	end

	`SBFD_ASSERT_IMPL(a_push_room, push, !q_full, "frame pushed into a full queue")
	`SBFD_ASSERT_NEXT(a_count_hold, !push, $stable(frames_q), "frame count moved without a frame")
	`SBFD_ASSERT_NEXT(a_last_data, take && (phase_q == PH_DATA) && (byte_cnt_q == 5'd22),
		phase_q == PH_END, "parser missed the end byte position")

endmodule

[sv/sbfd_queue.sv]
// Short register queue of whole frames between the parser and the unpacker.
// Depends on sbfd_pkg for the frame entry type and on assert_macros.svh.
`include "assert_macros.svh"
module sbfd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sbfd_pkg::frame_t push_frame,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output sbfd_pkg::frame_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sbfd_pkg::frame_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign full = (fill_q == CW'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_frame;
		end
	end

	`SBFD_ASSERT_IMPL(a_no_overflow, push, !full || pop, "push into a full frame queue")
	`SBFD_ASSERT_IMPL(a_no_underflow, pop, not_empty, "pop from an empty frame queue")

endmodule

[sv/sbfd_back.sv]
// Channel unpacker: emits sixteen 11-bit channels per queued frame.
// Depends on sbfd_pkg and assert_macros.svh; reads the head of the frame queue and pops it.
`include "assert_macros.svh"
module sbfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  sbfd_pkg::frame_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [3:0]       channel_index,
	output logic [10:0]      channel_value,
	output logic             digital_ch17,
	output logic             digital_ch18,
	output logic             frame_lost,
	output logic             failsafe_active,
	output logic [31:0]      frames_received,
	output logic             last_channel
);

	logic [3:0]  ch_q;
	logic        valid_q;
	logic        advance;
	logic        last_ch;
	logic [7:0]  bitpos;
	logic [3:0]  index_q;
	logic [10:0] value_q;
	logic [3:0]  flags_q;
	logic [31:0] count_q;
	logic        last_q;

	assign advance = q_not_empty && (!valid_q || out_ready);
	assign last_ch = (ch_q == 4'(sbfd_pkg::NUM_CHANNELS - 1));
	assign pop = advance && last_ch;
	assign bitpos = 8'(ch_q) * 8'(sbfd_pkg::CH_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			ch_q <= ch_q + 4'd1;
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			index_q <= ch_q;
			value_q <= head.chan_bits[bitpos +: sbfd_pkg::CH_BITS];
			flags_q <= head.flags;
			count_q <= head.count;
			last_q <= last_ch;
		end
	end

	assign out_valid = valid_q;
	assign channel_index = index_q;
	assign channel_value = value_q;
	assign digital_ch17 = flags_q[3];
	assign digital_ch18 = flags_q[2];
	assign frame_lost = flags_q[1];
	assign failsafe_active = flags_q[0];
	assign frames_received = count_q;
	assign last_channel = last_q;

	`SBFD_ASSERT_NEXT(a_pop_marks_last, pop, valid_q && last_q, "frame retired without last item")
	`SBFD_ASSERT_NEXT(a_first_after_pop, pop, ch_q == '0, "channel counter not rewound")

endmodule

[sv/sbfd_top_dummy_guard.sv]
// Frame handoff check between the parser and the unpacker of the SBUS decoder.
// Depends on assert_macros.svh; watches queue traffic only.
`include "assert_macros.svh"
module sbfd_handoff_chk (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic pop,
	input logic q_not_empty
);

	logic pending_q;

	// Remembers that a frame went in while the queue was empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else begin
			pending_q <= push && !q_not_empty;
		end
	end

	`SBFD_ASSERT_IMPL(a_push_seen, pending_q, q_not_empty, "pushed frame not visible to unpacker")
	`SBFD_ASSERT_IMPL(a_pop_has_data, pop, q_not_empty, "unpacker retired a missing frame")

endmodule

[sv/sbus_frame_decoder.sv]
// SBUS frame decoder: one received byte per cycle unless stalled, 16 channel items per frame.
// After its end byte is accepted, a frame enters the queue, then the unpacker output register.
// The parser stalls only the end byte, while the queue is full; the unpacker emits one item
// per cycle from a QUEUE_DEPTH-frame queue while a frame is queued and out_ready allows.
// Reset (arst_n low, asynchronous) clears the parser state, frame count, queue and output
// valid; frame storage is not cleared and needs no clearing pass.
`include "assert_macros.svh"
module sbus_frame_decoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  channel_index,
	output logic [10:0] channel_value,
	output logic        digital_ch17,
	output logic        digital_ch18,
	output logic        frame_lost,
	output logic        failsafe_active,
	output logic [31:0] frames_received,
	output logic        last_channel
);

	sbfd_pkg::frame_t push_frame;
	sbfd_pkg::frame_t head;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_not_empty;

	sbfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.q_full     (q_full),
		.push       (push),
		.push_frame (push_frame)
	);

	sbfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	sbfd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_not_empty     (q_not_empty),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.channel_index   (channel_index),
		.channel_value   (channel_value),
		.digital_ch17    (digital_ch17),
		.digital_ch18    (digital_ch18),
		.frame_lost      (frame_lost),
		.failsafe_active (failsafe_active),
		.frames_received (frames_received),
		.last_channel    (last_channel)
	);

	sbfd_handoff_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.pop         (pop),
		.q_not_empty (q_not_empty)
	);

	`SBFD_ASSERT_IMPL(a_idle_out, !q_not_empty && !out_valid, !pop, "pop with nothing queued")

endmodule
